// ===== sv/lfia_pkg.sv =====
// Shared types and constants for the lowest free index allocator.
// No dependencies; imported by lfia_ctrl, the top level, the checker and the testbench.
package lfia_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int KEY_W = 128;
    localparam int IN_W = 2 * KEY_W;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_GROUP  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_DUPLICATE = 2'd3
    } status_t;

    typedef struct packed {
        logic ready;
        logic load;
    } hs_t;

endpackage

// ===== sv/lfia_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module lfia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/lfia_ctrl.sv =====
// Sequencer for the allocator: slot scan, key compare, valid bits and held count.
// Depends on lfia_pkg; drives the key RAMs instantiated in the top level.
module lfia_ctrl
    import lfia_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int IDX_W = $clog2(SLOT_COUNT),
    parameter int CNT_W = $clog2(SLOT_COUNT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [1:0]       item_kind,
    input  logic [IN_W-1:0]  item_key,
    input  logic [CNT_W-1:0] limit,
    input  logic             out_free,
    output hs_t              hs,
    output status_t          res_status,
    output logic [IDX_W-1:0] res_slot,
    output logic [CNT_W-1:0] res_freed,
    output logic [CNT_W-1:0] res_held,
    output logic [CNT_W-1:0] res_spare,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_addr,
    output logic [KEY_W-1:0] grp_wdata,
    output logic [KEY_W-1:0] job_wdata,
    input  logic [KEY_W-1:0] grp_rdata,
    input  logic [KEY_W-1:0] job_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

    state_t            state_reg, state_next;
    logic [1:0]        kind_reg;
    logic [KEY_W-1:0]  grp_reg, job_reg;
    logic              full_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [CNT_W-1:0]  held_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [CNT_W-1:0]  freed_reg;
    logic [IDX_W-1:0]  first_idx_reg;

    logic              take;
    logic              full_now;
    logic              slot_v, m_grp, m_key, is_free;
    logic [CNT_W-1:0]  held_fin;
    logic              set_v, clr_v, add_we;
    logic              load;

    assign take = item_valid && (state_reg == ST_IDLE);
    assign full_now = (held_reg >= limit) || (held_reg == FULL_CNT);

    assign slot_v  = valid_reg[cmp_idx_reg];
    assign m_grp   = cmp_vld_reg && slot_v && (grp_rdata == grp_reg);
    assign m_key   = m_grp && (job_rdata == job_reg);
    assign is_free = cmp_vld_reg && !slot_v;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (item_kind)
                        KIND_ADD:    state_next = full_now ? ST_DONE : ST_SCAN;
                        KIND_REMOVE: state_next = ST_SCAN;
                        KIND_GROUP:  state_next = ST_SCAN;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_addr_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_status = STAT_NOT_FOUND;
        res_slot   = '0;
        res_freed  = '0;
        held_fin   = held_reg;
        set_v      = 1'b0;
        clr_v      = 1'b0;
        add_we     = 1'b0;
        case (kind_reg)
            KIND_ADD:
            begin
                if (full_reg)
                begin
                    res_status = STAT_FULL;
                end
                else if (hit_reg)
                begin
                    res_status = STAT_DUPLICATE;
                    res_slot   = hit_idx_reg;
                end
                else
                begin
                    res_status = STAT_OK;
                    res_slot   = free_idx_reg;
                    held_fin   = held_reg + CNT_W'(1);
                    set_v      = 1'b1;
                    add_we     = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (hit_reg)
                begin
                    res_status = STAT_OK;
                    res_slot   = hit_idx_reg;
                    res_freed  = CNT_W'(1);
                    clr_v      = 1'b1;
                    held_fin   = (held_reg != '0) ? held_reg - CNT_W'(1) : held_reg;
                end
            end
            KIND_GROUP:
            begin
                if (freed_reg != '0)
                begin
                    res_status = STAT_OK;
                    res_slot   = first_idx_reg;
                    res_freed  = freed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_held  = held_fin;
    assign res_spare = (limit > held_fin) ? limit - held_fin : '0;

    assign load      = (state_reg == ST_DONE) && out_free;
    assign hs.ready  = (state_reg == ST_IDLE);
    assign hs.load   = load;
    assign ram_we    = load && add_we;
    assign ram_addr  = (state_reg == ST_DONE) ? free_idx_reg : rd_addr_reg;
    assign grp_wdata = grp_reg;
    assign job_wdata = job_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            grp_reg <= item_key[KEY_W-1:0];
            job_reg <= item_key[IN_W-1:KEY_W];
        end
        cmp_idx_reg <= rd_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= '0;
            full_reg       <= 1'b0;
            rd_addr_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            valid_reg      <= '0;
            held_reg       <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            freed_reg      <= '0;
            first_idx_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (take)
            begin
                kind_reg       <= item_kind;
                full_reg       <= full_now;
                rd_addr_reg    <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                freed_reg      <= '0;
            end
            else if ((state_reg == ST_SCAN) && (rd_addr_reg != LAST_IDX))
            begin
                rd_addr_reg <= rd_addr_reg + IDX_W'(1);
            end
            if (m_key && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
            if (is_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
            if ((kind_reg == KIND_GROUP) && m_grp)
            begin
                valid_reg[cmp_idx_reg] <= 1'b0;
                freed_reg              <= freed_reg + CNT_W'(1);
                if (freed_reg == '0)
                begin
                    first_idx_reg <= cmp_idx_reg;
                end
                if (held_reg != '0)
                begin
                    held_reg <= held_reg - CNT_W'(1);
                end
            end
            if (load)
            begin
                held_reg <= held_fin;
                if (set_v)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                if (clr_v)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== sv/lowest_free_index_allocator_top.sv =====
// Top level of the lowest free index allocator: size limit register, key RAMs,
// sequencer and output register. Depends on lfia_pkg, lfia_ram and lfia_ctrl.
//
// Use: words enter on the s_ channel (kind in s_tuser, group and job keys in
// s_tdata) and one result word per input leaves on the m_ channel (status in
// m_tuser; slot, freed, held and spare counts in m_tdata). The user must write
// the size limit through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block itself does not enforce this. Add, remove and group-remove words
// scan every slot of the key RAMs, one slot a cycle through the single RAM
// port; the sequencer then passes through its drain state to its done state,
// where the result is loaded into the output register once that register is
// free. A full add or an unused kind needs no scan and goes straight to the
// done state. One word is in work at a time; s_tready is high while the
// sequencer is idle, also while a finished result still waits in the output
// register.
// When the receiver stalls, the result holds in the output register and the
// following word completes its scan and then waits until that register frees.
// Reset clears all valid bits, the held count and m_tvalid, and sets the
// size limit to SLOT_COUNT; no clearing pass runs over the RAMs.
module lowest_free_index_allocator_top
    import lfia_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int IDX_W = $clog2(SLOT_COUNT),
    parameter int CNT_W = $clog2(SLOT_COUNT + 1),
    parameter int OUT_W = ((IDX_W + 3 * CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,   // size_limit
    input  logic             s_tvalid,
    output logic             s_tready,
    // group_id_high, group_id_low, job_id_high, job_id_low
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [1:0]       s_tuser,       // kind
    output logic             m_tvalid,
    input  logic             m_tready,
    // slot_index, freed_count, held_count, spare_capacity, zero fill
    output logic [OUT_W-1:0] m_tdata,
    output logic [1:0]       m_tuser        // status
);

    logic [CNT_W-1:0] limit_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    hs_t              hs;
    status_t          res_status;
    logic [IDX_W-1:0] res_slot;
    logic [CNT_W-1:0] res_freed, res_held, res_spare;
    logic             out_free;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [KEY_W-1:0] grp_wdata, job_wdata, grp_rdata, job_rdata;

    assign out_free = !m_tvalid_reg || m_tready;

    lfia_ctrl #(
        .SLOT_COUNT(SLOT_COUNT),
        .IDX_W(IDX_W),
        .CNT_W(CNT_W)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(s_tvalid),
        .item_kind(s_tuser),
        .item_key(s_tdata),
        .limit(limit_reg),
        .out_free(out_free),
        .hs(hs),
        .res_status(res_status),
        .res_slot(res_slot),
        .res_freed(res_freed),
        .res_held(res_held),
        .res_spare(res_spare),
        .ram_we(ram_we),
        .ram_addr(ram_addr),
        .grp_wdata(grp_wdata),
        .job_wdata(job_wdata),
        .grp_rdata(grp_rdata),
        .job_rdata(job_rdata)
    );

    lfia_ram #(
        .WIDTH(KEY_W),
        .DEPTH(SLOT_COUNT),
        .AW(IDX_W)
    ) u_grp_ram (
        .clk(clk),
        .we(ram_we),
        .addr(ram_addr),
        .wdata(grp_wdata),
        .rdata(grp_rdata)
    );

    lfia_ram #(
        .WIDTH(KEY_W),
        .DEPTH(SLOT_COUNT),
        .AW(IDX_W)
    ) u_job_ram (
        .clk(clk),
        .we(ram_we),
        .addr(ram_addr),
        .wdata(job_wdata),
        .rdata(job_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= CNT_W'(SLOT_COUNT);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (hs.load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hs.load)
        begin
            m_tdata_reg <= OUT_W'({res_spare, res_held, res_freed, res_slot});
            m_tuser_reg <= res_status;
        end
    end

    assign s_tready = hs.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== sv/lfia_checker.sv =====
// Port-level checks for the allocator and the bind that attaches them.
// Depends on lfia_pkg and lowest_free_index_allocator_top.
module lfia_checker
    import lfia_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int IDX_W = $clog2(SLOT_COUNT),
    parameter int CNT_W = $clog2(SLOT_COUNT + 1),
    parameter int OUT_W = ((IDX_W + 3 * CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic [1:0]       m_tuser
);

    logic [IDX_W-1:0] slot_f;
    logic [CNT_W-1:0] freed_f, held_f;

    assign slot_f  = m_tdata[IDX_W-1:0];
    assign freed_f = m_tdata[IDX_W+CNT_W-1:IDX_W];
    assign held_f  = m_tdata[IDX_W+2*CNT_W-1:IDX_W+CNT_W];

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (held_f <= CNT_W'(SLOT_COUNT)))
        else $error("held count beyond slot count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == STAT_FULL) || (m_tuser == STAT_NOT_FOUND))
        |-> (slot_f == '0) && (freed_f == '0))
        else $error("failed word carries a slot or a freed count");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in work");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind lowest_free_index_allocator_top lfia_checker #(
    .SLOT_COUNT(SLOT_COUNT)
) u_lfia_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for lowest_free_index_allocator_top: drives add, remove,
// group-remove and unused-kind words and compares every result word with a slot
// table kept alongside. Depends on lfia_pkg and the RTL of the block.
module tb;
    import lfia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int OUT_W = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD = 600;
    localparam int N_GROUPS = 6;
    localparam int N_JOBS = 12;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] group_hi;
        logic [63:0] group_lo;
        logic [63:0] job_hi;
        logic [63:0] job_lo;
    } job_word_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  slot;
        logic [6:0]  freed;
        logic [6:0]  held;
        logic [6:0]  spare;
    } slot_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [6:0]       cfg_wr_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    lowest_free_index_allocator_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #2 clk = ~clk;

    // slot table shadow
    logic        slot_busy [SLOTS];
    logic [63:0] slot_group_hi [SLOTS];
    logic [63:0] slot_group_lo [SLOTS];
    logic [63:0] slot_job_hi [SLOTS];
    logic [63:0] slot_job_lo [SLOTS];
    int          held_slots = 0;
    logic [6:0]  limit_shadow = 7'd64;

    job_word_t    pending_words[$];
    slot_result_t awaited_results[$];
    job_word_t    offered_word;

    int  mismatches = 0;
    int  words_accepted = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    int  deepest_held = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;
    bit  hold_request = 1'b0;
    int  send_gap = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    logic [63:0] group_pool_hi [N_GROUPS];
    logic [63:0] group_pool_lo [N_GROUPS];
    logic [63:0] job_pool_hi [N_JOBS];
    logic [63:0] job_pool_lo [N_JOBS];

    function automatic int find_slot(job_word_t w, bit with_job);
        for (int s = 0; s < SLOTS; s++)
            if (slot_busy[s] && slot_group_hi[s] == w.group_hi && slot_group_lo[s] == w.group_lo
                && (!with_job || (slot_job_hi[s] == w.job_hi && slot_job_lo[s] == w.job_lo)))
                return s;
        return -1;
    endfunction

    function automatic slot_result_t allocate_slot(job_word_t w);
        slot_result_t r;
        int free_idx;
        int hit;
        r.status = STAT_NOT_FOUND;
        r.slot = '0;
        r.freed = '0;
        case (w.kind)
            KIND_ADD:
            begin
                free_idx = -1;
                for (int s = 0; s < SLOTS; s++)
                    if (!slot_busy[s])
                    begin
                        free_idx = s;
                        break;
                    end
                if (held_slots >= int'(limit_shadow) || free_idx < 0)
                    r.status = STAT_FULL;
                else
                begin
                    hit = find_slot(w, 1'b1);
                    if (hit >= 0)
                    begin
                        r.status = STAT_DUPLICATE;
                        r.slot = hit[5:0];
                    end
                    else
                    begin
                        slot_busy[free_idx] = 1'b1;
                        slot_group_hi[free_idx] = w.group_hi;
                        slot_group_lo[free_idx] = w.group_lo;
                        slot_job_hi[free_idx] = w.job_hi;
                        slot_job_lo[free_idx] = w.job_lo;
                        held_slots++;
                        r.status = STAT_OK;
                        r.slot = free_idx[5:0];
                    end
                end
            end
            KIND_REMOVE:
            begin
                hit = find_slot(w, 1'b1);
                if (hit >= 0)
                begin
                    slot_busy[hit] = 1'b0;
                    if (held_slots > 0)
                        held_slots--;
                    r.status = STAT_OK;
                    r.slot = hit[5:0];
                    r.freed = 7'd1;
                end
            end
            KIND_GROUP:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_busy[s] && slot_group_hi[s] == w.group_hi
                        && slot_group_lo[s] == w.group_lo)
                    begin
                        if (r.freed == 0)
                            r.slot = s[5:0];
                        slot_busy[s] = 1'b0;
                        r.freed++;
                        if (held_slots > 0)
                            held_slots--;
                    end
                if (r.freed > 0)
                    r.status = STAT_OK;
            end
            default:
            begin
            end
        endcase
        r.held = held_slots[6:0];
        r.spare = (int'(limit_shadow) > held_slots) ? limit_shadow - held_slots[6:0] : 7'd0;
        if (held_slots > deepest_held)
            deepest_held = held_slots;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sender
    always @(posedge clk)
    begin : drive_words
        logic next_valid;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(allocate_slot(offered_word));
                words_accepted++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                next_valid = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_words.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 12) - 1;
                    else
                    begin
                        offered_word = pending_words.pop_front();
                        s_tdata <= {offered_word.job_lo, offered_word.job_hi,
                                    offered_word.group_lo, offered_word.group_hi};
                        s_tuser <= offered_word.kind;
                        next_valid = 1'b1;
                    end
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin : watch_results
        slot_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with nothing awaited: status %0d, data %h",
                           m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("slot_index", want.slot, m_tdata[5:0]);
                    check_field("freed_count", want.freed, m_tdata[12:6]);
                    check_field("held_count", want.held, m_tdata[19:13]);
                    check_field("spare_capacity", want.spare, m_tdata[26:20]);
                    status_seen[want.status]++;
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_word(logic [1:0] kind, logic [63:0] g_hi, logic [63:0] g_lo,
                              logic [63:0] j_hi, logic [63:0] j_lo);
        job_word_t w;
        w.kind = kind;
        w.group_hi = g_hi;
        w.group_lo = g_lo;
        w.job_hi = j_hi;
        w.job_lo = j_lo;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [6:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        limit_shadow = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random_phase(int count, int add_pct);
        int r;
        int g;
        int j;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            g = $urandom_range(0, N_GROUPS - 1);
            j = $urandom_range(0, N_JOBS - 1);
            if (r < add_pct)
                queue_word(KIND_ADD, group_pool_hi[g], group_pool_lo[g],
                           job_pool_hi[j], job_pool_lo[j]);
            else if (r < add_pct + (92 - add_pct) * 3 / 4)
                queue_word(KIND_REMOVE, group_pool_hi[g], group_pool_lo[g],
                           job_pool_hi[j], job_pool_lo[j]);
            else if (r < 96)
                queue_word(KIND_GROUP, group_pool_hi[g], group_pool_lo[g], rand64(), rand64());
            else if (r < 98)
                queue_word(KIND_UNUSED, rand64(), rand64(), rand64(), rand64());
            else
                queue_word(2'($urandom_range(1, 2)), rand64(), rand64(), rand64(), rand64());
        end
    endtask

    initial
    begin : stimulus
        logic [63:0] ones;
        logic [63:0] g_a;
        logic [6:0]  phase_limit [9];
        int          phase_add [9];
        ones = '1;
        g_a = rand64();
        phase_limit = '{7'd64, 7'd127, 7'd5, 7'd40, 7'd1, 7'd0, 7'd127, 7'd20, 7'd64};
        phase_add = '{60, 85, 30, 55, 50, 50, 70, 45, 55};
        for (int i = 0; i < SLOTS; i++)
            slot_busy[i] = 1'b0;
        for (int i = 0; i < N_GROUPS; i++)
        begin
            group_pool_hi[i] = rand64();
            group_pool_lo[i] = rand64();
        end
        for (int i = 0; i < N_JOBS; i++)
        begin
            job_pool_hi[i] = rand64();
            job_pool_lo[i] = rand64();
        end
        // near misses: same high or same low word, the other word different
        group_pool_hi[1] = group_pool_hi[0];
        job_pool_hi[1] = job_pool_hi[0];
        job_pool_lo[2] = job_pool_lo[0];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        queue_word(KIND_REMOVE, '0, '0, '0, '0);
        queue_word(KIND_GROUP, '0, '0, '0, '0);
        queue_word(KIND_UNUSED, ones, ones, ones, ones);
        queue_word(KIND_ADD, '0, '0, '0, '0);
        queue_word(KIND_ADD, ones, ones, ones, ones);
        queue_word(KIND_ADD, ones, ones, ones, ones);
        queue_word(KIND_ADD, ones, ones, '0, '0);
        queue_word(KIND_ADD, ones, ones, ones, '0);
        queue_word(KIND_ADD, ones, '0, ones, ones);
        queue_word(KIND_REMOVE, ones, ones, ones, ones);
        queue_word(KIND_ADD, g_a, g_a, ones, ones);
        queue_word(KIND_REMOVE, '0, '0, '0, '0);
        queue_word(KIND_GROUP, ones, ones, '0, '0);
        queue_word(KIND_UNUSED, '0, '0, '0, '0);
        write_limit(7'd2);
        queue_word(KIND_ADD, g_a, g_a, '0, ones);
        queue_word(KIND_ADD, g_a, g_a, ones, '0);
        queue_word(KIND_ADD, g_a, g_a, ones, ones);
        write_limit(7'd0);
        queue_word(KIND_ADD, '0, ones, '0, ones);
        queue_word(KIND_REMOVE, g_a, g_a, ones, ones);
        write_limit(7'd127);
        queue_word(KIND_GROUP, g_a, g_a, ones, ones);
        queue_word(KIND_GROUP, ones, '0, '0, '0);
        queue_word(KIND_ADD, '0, ones, '0, ones);

        for (int p = 0; p < 9; p++)
        begin
            write_limit(phase_limit[p]);
            if (p == 8)
                quiet = 1'b1;
            queue_random_phase(170, phase_add[p]);
            // hold the receiver while the sender keeps offering
            if (p == 1)
                hold_request = 1'b1;
        end

        wait_idle();
        repeat (80) @(posedge clk);
        $display("%0d words: %0d ok, %0d full, %0d not found, %0d duplicate",
                 words_accepted, status_seen[STAT_OK], status_seen[STAT_FULL],
                 status_seen[STAT_NOT_FOUND], status_seen[STAT_DUPLICATE]);
        $display("size limits 0 to 127 exercised, at most %0d slots held at once", deepest_held);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
